### design/median_of_loaded_set_top_assert.svh
// Assertion helpers for the median block. All checks are clocked on clk_i
// and switched off while rst_ni is low.
`ifndef MEDIAN_OF_LOADED_SET_TOP_ASSERT_SVH
`define MEDIAN_OF_LOADED_SET_TOP_ASSERT_SVH

// Same-cycle implication.
`define MOS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("median block: same-cycle check failed");

// Next-cycle implication.
`define MOS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("median block: next-cycle check failed");

`endif

### design/mos_pkg.sv
`timescale 1ns / 1ps

package mos_pkg;

  localparam int unsigned MAX_SAMPLES = 64;
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int unsigned ADDR_W   = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned MEDIAN_W = SAMPLE_BITS + 1;
  localparam int unsigned BIT_W    = $clog2(SAMPLE_BITS);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CNT_W-1:0]       count_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [MEDIAN_W-1:0]    median_t;
  typedef logic [BIT_W-1:0]       bit_idx_t;

  localparam count_t   MAX_COUNT = count_t'(MAX_SAMPLES);
  localparam bit_idx_t TOP_BIT   = bit_idx_t'(SAMPLE_BITS - 1);

  typedef enum logic [1:0] {
    TOP_LOAD,
    TOP_SELECT,
    TOP_EMIT
  } top_state_e;

  typedef enum logic [1:0] {
    SEL_IDLE,
    SEL_SCAN,
    SEL_WAIT,
    SEL_DECIDE
  } sel_state_e;

  typedef struct packed {
    logic   start;
    count_t count;
  } sel_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sel_stat_t;

endpackage

### design/mos_channels.sv
`timescale 1ns / 1ps

interface mos_in_if;
  import mos_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    no_sample;
  logic    last;

  modport source (output valid, output sample, output no_sample, output last, input ready);
  modport sink   (input valid, input sample, input no_sample, input last, output ready);
endinterface

interface mos_out_if;
  import mos_pkg::*;

  logic    valid;
  logic    ready;
  median_t median_twice;
  logic    empty_error;
  logic    overflow;
  count_t  sample_count;

  modport source (output valid, output median_twice, output empty_error, output overflow,
                  output sample_count, input ready);
  modport sink   (input valid, input median_twice, input empty_error, input overflow,
                  input sample_count, output ready);
endinterface

### design/mos_sample_ram.sv
`timescale 1ns / 1ps

module mos_sample_ram (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  mos_pkg::addr_t  wr_addr_i,
  input  mos_pkg::sample_t wr_data_i,
  input  logic            rd_en_i,
  input  mos_pkg::addr_t  rd_addr_i,
  output mos_pkg::sample_t rd_data_o
);
  import mos_pkg::*;

  sample_t mem_q [MAX_SAMPLES];
  sample_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/mos_select.sv
`timescale 1ns / 1ps

// Radix selection: one pass over the store per sample bit, MSB first.
// Two ranks are tracked at once, (n-1)/2 and n/2; their sum is twice the median.
module mos_select (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mos_pkg::sel_ctrl_t ctrl_i,
  output mos_pkg::sel_stat_t stat_o,
  output logic               rd_en_o,
  output mos_pkg::addr_t     rd_addr_o,
  input  mos_pkg::sample_t   rd_data_i,
  output mos_pkg::median_t   median_twice_o
);
  import mos_pkg::*;

  sel_state_e state_q, state_d;
  logic       done_q, done_d;
  logic       rvalid_q;

  bit_idx_t   bit_q;
  count_t     addr_q, n_q;
  sample_t    pfx0_q, pfx1_q;
  count_t     k0_q, k1_q;
  count_t     c0_q, c1_q;

  logic       last_issue;
  sample_t    hi_mask, bit_mask;
  logic       hit0, hit1;
  logic       take0, take1;

  assign last_issue = (addr_q == n_q - count_t'(1));
  assign hi_mask    = sample_t'({SAMPLE_BITS{1'b1}} << bit_q);
  assign bit_mask   = sample_t'(1) << bit_q;

  // prefix bit under test is still zero, so one masked compare covers
  // "upper bits match and this bit is zero"
  assign hit0  = ((rd_data_i ^ pfx0_q) & hi_mask) == '0;
  assign hit1  = ((rd_data_i ^ pfx1_q) & hi_mask) == '0;
  assign take0 = (k0_q >= c0_q);
  assign take1 = (k1_q >= c1_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      SEL_IDLE:   if (ctrl_i.start) state_d = SEL_SCAN;
      SEL_SCAN:   if (last_issue) state_d = SEL_WAIT;
      SEL_WAIT:   state_d = SEL_DECIDE;
      SEL_DECIDE: state_d = (bit_q == '0) ? SEL_IDLE : SEL_SCAN;
      default:    state_d = SEL_IDLE;
    endcase
  end

  always_comb begin
    rd_en_o   = (state_q == SEL_SCAN);
    rd_addr_o = addr_q[ADDR_W-1:0];
    done_d    = (state_q == SEL_DECIDE) && (bit_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SEL_IDLE;
      done_q   <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      rvalid_q <= rd_en_o;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SEL_IDLE: begin
        if (ctrl_i.start) begin
          n_q    <= ctrl_i.count;
          bit_q  <= TOP_BIT;
          addr_q <= '0;
          pfx0_q <= '0;
          pfx1_q <= '0;
          k0_q   <= (ctrl_i.count - count_t'(1)) >> 1;
          k1_q   <= ctrl_i.count >> 1;
          c0_q   <= '0;
          c1_q   <= '0;
        end
      end
      SEL_SCAN, SEL_WAIT: begin
        if (state_q == SEL_SCAN) begin
          addr_q <= addr_q + count_t'(1);
        end
        if (rvalid_q) begin
          c0_q <= c0_q + count_t'(hit0);
          c1_q <= c1_q + count_t'(hit1);
        end
      end
      SEL_DECIDE: begin
        if (take0) begin
          pfx0_q <= pfx0_q | bit_mask;
          k0_q   <= k0_q - c0_q;
        end
        if (take1) begin
          pfx1_q <= pfx1_q | bit_mask;
          k1_q   <= k1_q - c1_q;
        end
        c0_q   <= '0;
        c1_q   <= '0;
        addr_q <= '0;
        if (bit_q != '0) begin
          bit_q <= bit_q - bit_idx_t'(1);
        end
      end
      default: ;
    endcase
  end

  assign stat_o.busy    = (state_q != SEL_IDLE);
  assign stat_o.done    = done_q;
  assign median_twice_o = median_t'(pfx0_q) + median_t'(pfx1_q);

endmodule

### design/median_of_loaded_set_top.sv
`timescale 1ns / 1ps

// Median of a loaded set of unsigned samples.
// Input channel in_i: one item per transfer. An item with no_sample low is
// written to the sample store (up to MAX_SAMPLES; later samples are dropped
// and the set is flagged as overflowed). An item with last high closes the
// set, after storing its own sample if it carries one.
// Output channel out_o: one result per closed set, giving twice the median
// (sum of the two middle samples for an even count), the sample count, the
// overflow flag, and empty_error for a set with no samples.
// Loading accepts one item per cycle. Closing a set of n samples runs a radix
// selection: SAMPLE_BITS passes over the store through its single read port.
// An empty set skips the selection and goes straight to the output register.
// No item is taken while a selection runs or while a result waits for the
// output register; loading of the next set resumes as soon as the result
// sits in the output register, even if the receiver stalls it. After reset
// the store is empty and no result is pending.
module median_of_loaded_set_top (
  input logic      clk_i,
  input logic      rst_ni,
  mos_in_if.sink   in_i,
  mos_out_if.source out_o
);
  import mos_pkg::*;

  top_state_e state_q, state_d;
  count_t     cnt_q, cnt_d;
  logic       ovf_q, ovf_d;
  logic       start_q, start_d;
  logic       empty_q, empty_d;

  logic       out_valid_q, out_valid_d;
  median_t    out_median_q;
  logic       out_empty_q, out_ovf_q;
  count_t     out_count_q;

  logic       in_fire, store_ok, empty_set, close_set, emit_load;

  sel_ctrl_t  sel_ctrl;
  sel_stat_t  sel_stat;
  logic       rd_en;
  addr_t      rd_addr;
  sample_t    rd_data;
  median_t    sel_median;

  assign in_fire   = in_i.valid && in_i.ready;
  assign store_ok  = in_fire && !in_i.no_sample && (cnt_q < MAX_COUNT);
  assign close_set = in_fire && in_i.last;
  // a sample on an empty store is always kept, so the set is empty only here
  assign empty_set = (cnt_q == '0) && in_i.no_sample;
  assign emit_load = (state_q == TOP_EMIT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      TOP_LOAD:   if (close_set) state_d = empty_set ? TOP_EMIT : TOP_SELECT;
      TOP_SELECT: if (sel_stat.done) state_d = TOP_EMIT;
      TOP_EMIT:   if (emit_load) state_d = TOP_LOAD;
      default:    state_d = TOP_LOAD;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == TOP_LOAD);
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    empty_d    = empty_q;
    start_d    = 1'b0;
    if (store_ok) begin
      cnt_d = cnt_q + count_t'(1);
    end else if (in_fire && !in_i.no_sample) begin
      ovf_d = 1'b1;
    end
    if (close_set) begin
      empty_d = empty_set;
      start_d = !empty_set;
    end
    if (emit_load) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (emit_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TOP_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      start_q     <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      start_q     <= start_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_median_q <= empty_q ? '0 : sel_median;
      out_empty_q  <= empty_q;
      out_ovf_q    <= ovf_q;
      out_count_q  <= empty_q ? '0 : cnt_q;
    end
  end

  assign sel_ctrl.start = start_q;
  assign sel_ctrl.count = cnt_q;

  mos_sample_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (store_ok),
    .wr_addr_i (cnt_q[ADDR_W-1:0]),
    .wr_data_i (in_i.sample),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  mos_select u_select (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (sel_ctrl),
    .stat_o         (sel_stat),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .median_twice_o (sel_median)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.median_twice = out_median_q;
  assign out_o.empty_error  = out_empty_q;
  assign out_o.overflow     = out_ovf_q;
  assign out_o.sample_count = out_count_q;

`include "median_of_loaded_set_top_assert.svh"

  `MOS_ASSERT_IMPL(a_start_idle, sel_ctrl.start, !sel_stat.busy)
  `MOS_ASSERT_IMPL(a_done_in_select, sel_stat.done, state_q == TOP_SELECT)
  `MOS_ASSERT_NEXT(a_count_step, store_ok, cnt_q == $past(cnt_q) + count_t'(1))
  `MOS_ASSERT_IMPL(a_no_read_while_loading, rd_en, state_q == TOP_SELECT)

endmodule

### verif/tb_median_of_loaded_set_top.sv
`timescale 1ns / 1ps

module tb_median_of_loaded_set_top;
  import mos_pkg::*;

  localparam int unsigned TOTAL_ITEMS = 1650;
  localparam int unsigned QUIET_FROM  = 1450;   // no idling on either side from here
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned SETTLE_CYCLES = 1100; // > one full-store selection
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    median_t median_twice;
    logic    empty_error;
    logic    overflow;
    count_t  sample_count;
  } median_result_t;

  // Tracks the set being loaded and the medians still owed by the block.
  class median_scoreboard;
    sample_t        open_set[$];
    bit             dropped;
    median_result_t expected_medians[$];
    int unsigned    errors;

    function void note_item(sample_t s, logic no_s, logic l);
      median_result_t r;
      sample_t        sorted[$];
      int unsigned    n;
      if (!no_s) begin
        if (open_set.size() < MAX_SAMPLES) open_set.insert(open_set.size(), s);
        else dropped = 1'b1;
      end
      if (!l) return;
      n = open_set.size();
      r.median_twice = '0;
      r.empty_error  = (n == 0);
      r.overflow     = dropped;
      r.sample_count = count_t'(n);
      if (n != 0) begin
        sorted = open_set;
        sorted.sort();
        if (n % 2 == 0) r.median_twice = median_t'(sorted[n/2]) + median_t'(sorted[n/2 - 1]);
        else r.median_twice = {sorted[n/2], 1'b0};
      end
      expected_medians.insert(expected_medians.size(), r);
      open_set.delete();
      dropped = 1'b0;
    endfunction

    function void check_result(median_result_t got);
      median_result_t want;
      if (expected_medians.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: median_twice %0d empty %0b ovf %0b count %0d",
                 $time, got.median_twice, got.empty_error, got.overflow, got.sample_count);
        return;
      end
      want = expected_medians.pop_front();
      if (got.median_twice !== want.median_twice) begin
        errors++;
        $display("%0t: median_twice expected %0d, actual %0d",
                 $time, want.median_twice, got.median_twice);
      end
      if (got.empty_error !== want.empty_error) begin
        errors++;
        $display("%0t: empty_error expected %0b, actual %0b",
                 $time, want.empty_error, got.empty_error);
      end
      if (got.overflow !== want.overflow) begin
        errors++;
        $display("%0t: overflow expected %0b, actual %0b", $time, want.overflow, got.overflow);
      end
      if (got.sample_count !== want.sample_count) begin
        errors++;
        $display("%0t: sample_count expected %0d, actual %0d",
                 $time, want.sample_count, got.sample_count);
      end
    endfunction

    function int unsigned pending();
      return expected_medians.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mos_in_if  in_ch ();
  mos_out_if out_ch ();

  median_of_loaded_set_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  median_scoreboard sb;
  int unsigned items_sent;
  int unsigned stall_cycles = 0;
  bit          quiet;
  bit          hold_req;
  bit          hold_done;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Transfer monitor and stall counter
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_item(in_ch.sample, in_ch.no_sample, in_ch.last);
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.median_twice, out_ch.empty_error, out_ch.overflow,
                          out_ch.sample_count});
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Receiver: random ready bursts, one long hold on request
  initial begin
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
      end else begin
        out_ch.ready = 1'b1;
        repeat ($urandom_range(1, 40) - 1) @(negedge clk_i);
      end
    end
  end

  // Offers one item and returns at the edge where it is transferred.
  // valid is left high so that back-to-back items need no extra cycle.
  task automatic send_item(sample_t s, logic no_s, logic l);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_ch.valid     = 1'b1;
    in_ch.sample    = s;
    in_ch.no_sample = no_s;
    in_ch.last      = l;
    do @(posedge clk_i); while (!in_ch.ready);
    if (!(no_s && !l)) items_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return sample_t'($urandom_range(0, 7));   // plenty of ties
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 0;
    if (r < 60) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(9, 32);
    if (r < 95) return $urandom_range(33, 64);
    return $urandom_range(65, 70);
  endfunction

  task automatic send_set(int unsigned n);
    bit close_on_sample;
    close_on_sample = (n != 0) && $urandom_range(0, 1);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) send_item(sample_t'($urandom), 1'b1, 1'b0);
      send_item(pick_sample(), 1'b0, close_on_sample && (i == n - 1));
    end
    if (!close_on_sample) send_item(sample_t'($urandom), 1'b1, 1'b1);
  endtask

  initial begin
    bit pressure_done;
    sb = new();
    pressure_done = 1'b0;
    quiet           = 1'b0;
    hold_req        = 1'b0;
    items_sent      = 0;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.sample    = '0;
    in_ch.no_sample = 1'b0;
    in_ch.last      = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty set, sample field ignored
    send_item(16'hFFFF, 1'b1, 1'b1);
    // single samples at both extremes, closed by the sample itself
    send_item(16'h0000, 1'b0, 1'b1);
    send_item(16'hFFFF, 1'b0, 1'b1);
    // even count at the top, a do-nothing item inside, separate close
    send_item(16'hFFFF, 1'b0, 1'b0);
    send_item(16'h1234, 1'b1, 1'b0);
    send_item(16'hFFFF, 1'b0, 1'b0);
    send_item(16'h0000, 1'b1, 1'b1);
    // odd count, unsorted
    send_item(16'h0000, 1'b0, 1'b0);
    send_item(16'hFFFF, 1'b0, 1'b0);
    send_item(16'h0001, 1'b0, 1'b1);
    // alternating bit patterns
    send_item(16'h5555, 1'b0, 1'b0);
    send_item(16'hAAAA, 1'b0, 1'b1);
    // ties in the middle
    send_item(16'd7, 1'b0, 1'b0);
    send_item(16'd7, 1'b0, 1'b0);
    send_item(16'd3, 1'b0, 1'b0);
    send_item(16'd9, 1'b0, 1'b1);
    // empty set straight after a non-empty one
    send_item(16'h8001, 1'b1, 1'b1);
    // descending run
    send_item(16'd50, 1'b0, 1'b0);
    send_item(16'd40, 1'b0, 1'b0);
    send_item(16'd30, 1'b0, 1'b0);
    send_item(16'd20, 1'b0, 1'b0);
    send_item(16'd10, 1'b0, 1'b1);

    // store overrun early on
    send_set(67);

    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= QUIET_FROM) quiet = 1'b1;
      if (!pressure_done && items_sent >= 500) begin
        // hold the output off and keep loading until the input stalls
        pressure_done = 1'b1;
        hold_req = 1'b1;
        repeat (4) send_set(4);
        wait_all_results();
      end
      send_set(pick_size());
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/mos_pkg.sv
design/mos_channels.sv
design/mos_sample_ram.sv
design/mos_select.sv
design/median_of_loaded_set_top.sv
verif/tb_median_of_loaded_set_top.sv
